### src/paged_frame_allocator_top_defines.svh
// assertion macros for the paged frame allocator
// no dependencies; included by the files that carry assertions
`ifndef PAGED_FRAME_ALLOCATOR_TOP_DEFINES_SVH
`define PAGED_FRAME_ALLOCATOR_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define PFA_ASSERT(name, clk, rstn, prop) \
    name: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("pfa assertion failed");
`define PFA_ASSERT_NEVER(name, clk, rstn, expr) \
    name: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
        else $error("pfa forbidden condition seen");
`else
`define PFA_ASSERT(name, clk, rstn, prop)
`define PFA_ASSERT_NEVER(name, clk, rstn, expr)
`endif

`endif

### src/pfa_pkg.sv
// shared types and constants of the paged frame allocator
// no dependencies; used by every module of the block but pfa_frame_mem
`default_nettype none

package pfa_pkg;

    localparam int NUM_FRAMES_DEF = 64;
    localparam int MAX_PAGES_DEF  = 16;
    localparam int PAGE_BYTES_DEF = 1024;

    localparam int TAG_W    = 8;
    localparam int BYTES_W  = 16;
    localparam int REL_W    = 6;
    localparam int STATUS_W = 2;
    localparam int PAGE_W   = 4;
    localparam int FRAME_W  = 6;

    // operand width of the shared unit: the page size can reach 65536
    localparam int DIV_W = 17;

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK       = 2'd0,
        STATUS_NOFRAMES = 2'd1,
        STATUS_LIMIT    = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV,
        ST_COUNT,
        ST_SCAN,
        ST_OUT,
        ST_RESP
    } state_t;

    typedef struct packed {
        logic [DIV_W-1:0] a;
        logic [DIV_W-1:0] b;
    } alu_req_t;

    typedef struct packed {
        logic [DIV_W-1:0] diff;
        logic             borrow;
        logic             eq;
    } alu_rsp_t;

endpackage

`default_nettype wire

### src/pfa_alu.sv
// shared subtract and compare unit of the allocator sequencer
// depends on pfa_pkg
`default_nettype none

module pfa_alu (
    input  pfa_pkg::alu_req_t req,
    output pfa_pkg::alu_rsp_t rsp
);

    logic [pfa_pkg::DIV_W:0] wide_diff;

    always_comb begin
        wide_diff  = {1'b0, req.a} - {1'b0, req.b};
        rsp.diff   = wide_diff[pfa_pkg::DIV_W-1:0];
        rsp.borrow = wide_diff[pfa_pkg::DIV_W];
        rsp.eq     = (req.a == req.b);
    end

endmodule

`default_nettype wire

### src/pfa_frame_mem.sv
// frame free map: one bit per physical frame, set when the frame is free
// one write port, one registered read port; depends on nothing
`default_nettype none

module pfa_frame_mem #(
    parameter int NUM_FRAMES = 64
) (
    input  wire                          aclk,
    input  wire                          we,
    input  wire [$clog2(NUM_FRAMES)-1:0] waddr,
    input  wire                          wdata,
    input  wire [$clog2(NUM_FRAMES)-1:0] raddr,
    output logic                         rdata
);

    logic free_mem [NUM_FRAMES];
    logic rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            free_mem[waddr] <= wdata;
        end
        rdata_reg <= free_mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### src/pfa_ctrl.sv
// sequencer of the allocator: page count division, two table passes, result register
// depends on pfa_pkg, pfa_alu (through ports) and the defines header
`default_nettype none
`include "paged_frame_allocator_top_defines.svh"

module pfa_ctrl #(
    parameter int NUM_FRAMES = pfa_pkg::NUM_FRAMES_DEF,
    parameter int MAX_PAGES  = pfa_pkg::MAX_PAGES_DEF,
    parameter int PAGE_BYTES = pfa_pkg::PAGE_BYTES_DEF
) (
    input  wire                                 aclk,
    input  wire                                 aresetn,
    input  wire                                 s_valid,
    output logic                                s_ready,
    input  wire                                 s_req_type,
    input  wire [pfa_pkg::TAG_W-1:0]            s_owner_tag,
    input  wire [pfa_pkg::BYTES_W-1:0]          s_request_bytes,
    input  wire [pfa_pkg::REL_W-1:0]            s_release_frame,
    output logic                                m_valid,
    input  wire                                 m_ready,
    output logic [pfa_pkg::STATUS_W-1:0]        m_status,
    output logic [pfa_pkg::PAGE_W-1:0]          m_page_number,
    output logic [pfa_pkg::FRAME_W-1:0]         m_frame_number,
    output logic                                m_frame_valid,
    output logic                                m_last,
    output pfa_pkg::alu_req_t                   alu_req,
    input  pfa_pkg::alu_rsp_t                   alu_rsp,
    output logic                                mem_we,
    output logic [$clog2(NUM_FRAMES)-1:0]       mem_waddr,
    output logic                                mem_wdata,
    output logic [$clog2(NUM_FRAMES)-1:0]       mem_raddr,
    input  wire                                 mem_rdata
);

    localparam int FA_W  = $clog2(NUM_FRAMES);
    localparam int IDX_W = $clog2(NUM_FRAMES + 1);
    localparam int PC_W  = $clog2(MAX_PAGES + 1);
    localparam int DIV_W = pfa_pkg::DIV_W;

    pfa_pkg::state_t             state_reg, state_next;
    logic [IDX_W-1:0]            idx_reg, idx_next;
    logic                        chk_valid_reg, chk_valid_next;
    logic [FA_W-1:0]             chk_addr_reg, chk_addr_next;
    logic [PC_W-1:0]             cnt_reg, cnt_next;
    logic [PC_W-1:0]             pages_reg, pages_next;
    logic [DIV_W-1:0]            dq_reg, dq_next;
    logic [pfa_pkg::TAG_W-1:0]   tag_reg, tag_next;
    logic [FA_W-1:0]             found_reg, found_next;
    pfa_pkg::status_t            resp_status_reg, resp_status_next;

    logic                        m_valid_reg, m_valid_next;
    pfa_pkg::status_t            m_status_reg, m_status_next;
    logic [pfa_pkg::PAGE_W-1:0]  m_page_reg, m_page_next;
    logic [pfa_pkg::FRAME_W-1:0] m_frame_reg, m_frame_next;
    logic                        m_fvalid_reg, m_fvalid_next;
    logic                        m_last_reg, m_last_next;

    logic             issue;
    logic             last_entry;
    logic             out_free;
    logic             out_load;
    logic             in_beat;

    assign s_ready    = (state_reg == pfa_pkg::ST_IDLE);
    assign in_beat    = s_valid && s_ready;
    assign out_free   = !m_valid_reg || m_ready;
    assign last_entry = (chk_addr_reg == FA_W'(NUM_FRAMES - 1));
    assign issue      = ((state_reg == pfa_pkg::ST_COUNT) || (state_reg == pfa_pkg::ST_SCAN))
                        && (idx_reg != IDX_W'(NUM_FRAMES));
    assign mem_raddr   = idx_reg[FA_W-1:0];

    // operand select for the shared unit
    always_comb begin
        case (state_reg)
            pfa_pkg::ST_DIV: begin
                alu_req.a = dq_reg;
                alu_req.b = DIV_W'(PAGE_BYTES);
            end
            default: begin
                alu_req.a = DIV_W'(pages_reg);
                alu_req.b = DIV_W'(cnt_reg) + DIV_W'(1);
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= pfa_pkg::ST_CLEAR;
            idx_reg       <= '0;
            chk_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            chk_valid_reg <= chk_valid_next;
            m_valid_reg   <= m_valid_next;
        end
        chk_addr_reg    <= chk_addr_next;
        cnt_reg         <= cnt_next;
        pages_reg       <= pages_next;
        dq_reg          <= dq_next;
        tag_reg         <= tag_next;
        found_reg       <= found_next;
        resp_status_reg <= resp_status_next;
        m_status_reg    <= m_status_next;
        m_page_reg      <= m_page_next;
        m_frame_reg     <= m_frame_next;
        m_fvalid_reg    <= m_fvalid_next;
        m_last_reg      <= m_last_next;
    end

    always_comb begin
        state_next       = state_reg;
        idx_next         = issue ? (idx_reg + IDX_W'(1)) : idx_reg;
        chk_valid_next   = issue;
        chk_addr_next    = idx_reg[FA_W-1:0];
        cnt_next         = cnt_reg;
        pages_next       = pages_reg;
        dq_next          = dq_reg;
        tag_next         = tag_reg;
        found_next       = found_reg;
        resp_status_next = resp_status_reg;
        mem_we           = 1'b0;
        mem_waddr        = idx_reg[FA_W-1:0];
        mem_wdata        = 1'b1;
        out_load         = 1'b0;
        m_status_next    = m_status_reg;
        m_page_next      = m_page_reg;
        m_frame_next     = m_frame_reg;
        m_fvalid_next    = m_fvalid_reg;
        m_last_next      = m_last_reg;

        unique case (state_reg)
            pfa_pkg::ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_wdata = 1'b1;
                idx_next  = idx_reg + IDX_W'(1);
                if (idx_reg == IDX_W'(NUM_FRAMES - 1)) begin
                    idx_next   = '0;
                    state_next = pfa_pkg::ST_IDLE;
                end
            end
            pfa_pkg::ST_IDLE: begin
                if (in_beat) begin
                    tag_next         = s_owner_tag;
                    resp_status_next = pfa_pkg::STATUS_OK;
                    if (s_req_type == pfa_pkg::REQ_FREE) begin
                        if (32'(s_release_frame) < 32'(NUM_FRAMES)) begin
                            mem_we    = 1'b1;
                            mem_waddr = FA_W'(s_release_frame);
                            mem_wdata = 1'b1;
                        end
                        state_next = pfa_pkg::ST_RESP;
                    end else begin
                        dq_next    = DIV_W'(s_request_bytes);
                        cnt_next   = '0;
                        state_next = pfa_pkg::ST_DIV;
                    end
                end
            end
            pfa_pkg::ST_DIV: begin
                // page count: take one page size off the bytes left each cycle
                if (dq_reg == '0) begin
                    if (cnt_reg == '0) begin
                        resp_status_next = pfa_pkg::STATUS_OK;
                        state_next       = pfa_pkg::ST_RESP;
                    end else begin
                        pages_next = cnt_reg;
                        cnt_next   = '0;
                        idx_next   = '0;
                        state_next = pfa_pkg::ST_COUNT;
                    end
                end else if (cnt_reg == PC_W'(MAX_PAGES)) begin
                    // bytes left over once the limit is reached
                    resp_status_next = pfa_pkg::STATUS_LIMIT;
                    state_next       = pfa_pkg::ST_RESP;
                end else begin
                    dq_next  = (alu_rsp.borrow || alu_rsp.eq) ? '0 : alu_rsp.diff;
                    cnt_next = cnt_reg + PC_W'(1);
                end
            end
            pfa_pkg::ST_COUNT: begin
                // first pass: are there enough free frames at all
                if (chk_valid_reg) begin
                    if (mem_rdata && alu_rsp.eq) begin
                        cnt_next       = '0;
                        idx_next       = '0;
                        chk_valid_next = 1'b0;
                        state_next     = pfa_pkg::ST_SCAN;
                    end else if (last_entry) begin
                        resp_status_next = pfa_pkg::STATUS_NOFRAMES;
                        chk_valid_next   = 1'b0;
                        state_next       = pfa_pkg::ST_RESP;
                    end else if (mem_rdata) begin
                        cnt_next = cnt_reg + PC_W'(1);
                    end
                end
            end
            pfa_pkg::ST_SCAN: begin
                // second pass: stop at each free frame and hand out one page
                if (chk_valid_reg && mem_rdata) begin
                    found_next     = chk_addr_reg;
                    idx_next       = IDX_W'(chk_addr_reg) + IDX_W'(1);
                    chk_valid_next = 1'b0;
                    state_next     = pfa_pkg::ST_OUT;
                end
            end
            pfa_pkg::ST_OUT: begin
                if (out_free) begin
                    out_load      = 1'b1;
                    m_status_next = pfa_pkg::STATUS_OK;
                    m_page_next   = pfa_pkg::PAGE_W'(cnt_reg);
                    m_frame_next  = pfa_pkg::FRAME_W'(found_reg);
                    m_fvalid_next = 1'b1;
                    m_last_next   = alu_rsp.eq;
                    // owner tag zero leaves the frame free
                    mem_we        = 1'b1;
                    mem_waddr     = found_reg;
                    mem_wdata     = (tag_reg == '0);
                    if (alu_rsp.eq) begin
                        state_next = pfa_pkg::ST_IDLE;
                    end else begin
                        cnt_next   = cnt_reg + PC_W'(1);
                        state_next = pfa_pkg::ST_SCAN;
                    end
                end
            end
            pfa_pkg::ST_RESP: begin
                if (out_free) begin
                    out_load      = 1'b1;
                    m_status_next = resp_status_reg;
                    m_page_next   = '0;
                    m_frame_next  = '0;
                    m_fvalid_next = 1'b0;
                    m_last_next   = 1'b1;
                    state_next    = pfa_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = pfa_pkg::ST_IDLE;
            end
        endcase

        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = m_status_reg;
    assign m_page_number  = m_page_reg;
    assign m_frame_number = m_frame_reg;
    assign m_frame_valid  = m_fvalid_reg;
    assign m_last         = m_last_reg;

    // the first pass guarantees the second never runs off the table
    `PFA_ASSERT_NEVER(a_scan_overrun, aclk, aresetn,
        (state_reg == pfa_pkg::ST_SCAN) && chk_valid_reg && last_entry && !mem_rdata)
    `PFA_ASSERT(a_cnt_below_pages, aclk, aresetn,
        ((state_reg == pfa_pkg::ST_SCAN) || (state_reg == pfa_pkg::ST_OUT)) |-> (cnt_reg < pages_reg))
    `PFA_ASSERT(a_alloc_write_with_beat, aclk, aresetn,
        (mem_we && (state_reg == pfa_pkg::ST_OUT)) |-> out_load)
    `PFA_ASSERT(a_busy_after_accept, aclk, aresetn, in_beat |=> !s_ready)

endmodule

`default_nettype wire

### src/paged_frame_allocator_top.sv
// paged frame allocator: first-fit assignment of physical frames to owner pages
//
// input channel (s_*): one beat is one request. s_req_type selects allocate or
// free. allocate asks for ceil(s_request_bytes / PAGE_BYTES) pages for
// s_owner_tag; free releases frame s_release_frame.
// result channel (m_*): an allocate that succeeds gives one beat per page, in
// page order, m_last on the final one; every other request gives one beat with
// m_last set and m_status telling ok, no frames, or page limit exceeded.
// a free goes from the accept to the response state, which loads its beat into the
// result register. an allocate counts pages by taking PAGE_BYTES off once a cycle,
// stopping at MAX_PAGES when bytes are left over, then makes a counting pass and
// a hand-out pass over the free map at one frame a cycle, both ending at the frame
// of the last page; the hand-out pass stops at each free frame to load the beat of
// one page and waits there while the result register is held. one request is
// worked on at a time, with the one-read-port free map and the shared subtract
// unit serving every step.
// reset: a clearing pass writes every frame free with s_ready low. a stalled
// m_ready holds the result register; the next request is still taken and waits
// only when it has a beat of its own to deliver.
// depends on pfa_pkg, pfa_ctrl, pfa_alu, pfa_frame_mem
`default_nettype none

module paged_frame_allocator_top #(
    parameter int NUM_FRAMES = pfa_pkg::NUM_FRAMES_DEF,
    parameter int MAX_PAGES  = pfa_pkg::MAX_PAGES_DEF,
    parameter int PAGE_BYTES = pfa_pkg::PAGE_BYTES_DEF
) (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          s_valid,
    output logic                         s_ready,
    input  wire                          s_req_type,
    input  wire [pfa_pkg::TAG_W-1:0]     s_owner_tag,
    input  wire [pfa_pkg::BYTES_W-1:0]   s_request_bytes,
    input  wire [pfa_pkg::REL_W-1:0]     s_release_frame,
    output logic                         m_valid,
    input  wire                          m_ready,
    output logic [pfa_pkg::STATUS_W-1:0] m_status,
    output logic [pfa_pkg::PAGE_W-1:0]   m_page_number,
    output logic [pfa_pkg::FRAME_W-1:0]  m_frame_number,
    output logic                         m_frame_valid,
    output logic                         m_last
);

    localparam int FA_W = $clog2(NUM_FRAMES);

    pfa_pkg::alu_req_t alu_req;
    pfa_pkg::alu_rsp_t alu_rsp;
    logic              mem_we;
    logic [FA_W-1:0]   mem_waddr;
    logic              mem_wdata;
    logic [FA_W-1:0]   mem_raddr;
    logic              mem_rdata;

    pfa_ctrl #(
        .NUM_FRAMES (NUM_FRAMES),
        .MAX_PAGES  (MAX_PAGES),
        .PAGE_BYTES (PAGE_BYTES)
    ) u_ctrl (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_req_type      (s_req_type),
        .s_owner_tag     (s_owner_tag),
        .s_request_bytes (s_request_bytes),
        .s_release_frame (s_release_frame),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_page_number   (m_page_number),
        .m_frame_number  (m_frame_number),
        .m_frame_valid   (m_frame_valid),
        .m_last          (m_last),
        .alu_req         (alu_req),
        .alu_rsp         (alu_rsp),
        .mem_we          (mem_we),
        .mem_waddr       (mem_waddr),
        .mem_wdata       (mem_wdata),
        .mem_raddr       (mem_raddr),
        .mem_rdata       (mem_rdata)
    );

    pfa_alu u_alu (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    pfa_frame_mem #(
        .NUM_FRAMES (NUM_FRAMES)
    ) u_frame_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

endmodule

`default_nettype wire
